/* design/plrp_pkg.sv */
// ----------------------------------------------------------------------------
// Peer list record parser package
// Shared widths, codes and the result and queue entry types.
// ----------------------------------------------------------------------------
package plrp_pkg;

	// Longest name that is forwarded; longer declared lengths are clamped.
	localparam logic [7:0] NAME_MAX = 8'd32;

	// Number of MAC bytes at the start of each record header.
	localparam logic [2:0] HDR_MAC_BYTES = 3'd6;
	// Header byte index of the RSSI byte.
	localparam logic [2:0] HDR_RSSI_IDX  = 3'd6;

	// Result kinds.
	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_NAME   = 2'd1;
	localparam logic [1:0] KIND_DONE   = 2'd2;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_PEER_LIMIT   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PEER_CHANNEL = 1'd1;

	// Queue between the parser front and the result back end.
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [1:0]        kind;
		logic [7:0]        peer_index;
		logic [47:0]       mac_address;
		logic signed [7:0] rssi;
		logic [3:0]        channel_out;
		logic [5:0]        name_length;
		logic [7:0]        name_byte;
		logic [4:0]        name_position;
		logic              name_end;
		logic [7:0]        peer_count;
	} result_t;

	// One queue entry per accepted byte that causes any result: an optional
	// header or name-byte result, then an optional done result.
	typedef struct packed {
		logic       has_main;
		logic       has_done;
		result_t    main;
		logic [7:0] done_count;
	} entry_t;

	// Queue status seen by the front and the back end.
	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

/* design/plrp_byte_if.sv */
// ----------------------------------------------------------------------------
// Payload byte channel
// Valid/ready channel carrying one payload byte and its last-byte flag.
// ----------------------------------------------------------------------------
interface plrp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

/* design/plrp_result_if.sv */
// ----------------------------------------------------------------------------
// Parser result channel
// Valid/ready channel carrying one header, name-byte or done result.
// ----------------------------------------------------------------------------
interface plrp_result_if;
	logic              valid;
	logic              ready;
	logic [1:0]        kind;
	logic [7:0]        peer_index;
	logic [47:0]       mac_address;
	logic signed [7:0] rssi;
	logic [3:0]        channel_out;
	logic [5:0]        name_length;
	logic [7:0]        name_byte;
	logic [4:0]        name_position;
	logic              name_end;
	logic [7:0]        peer_count;

	modport source (
		output valid, output kind, output peer_index, output mac_address, output rssi,
		output channel_out, output name_length, output name_byte, output name_position,
		output name_end, output peer_count, input ready
	);
	modport sink (
		input valid, input kind, input peer_index, input mac_address, input rssi,
		input channel_out, input name_length, input name_byte, input name_position,
		input name_end, input peer_count, output ready
	);
endinterface

/* design/plrp_cfg_if.sv */
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface plrp_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [plrp_pkg::CFG_IDX_W-1:0] index;
	logic [7:0]                    data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/peer_list_record_parser.sv */
// ----------------------------------------------------------------------------
// Peer list record parser
// Parses a peer list response payload byte by byte into peer header,
// name byte and done results.
// ----------------------------------------------------------------------------
//
//   Port      Dir   Transaction carries
//   payload   sink  data_byte, last_byte: one payload byte
//   result    src   kind, peer_index, mac_address, rssi, channel_out,
//                   name_length, name_byte, name_position, name_end, peer_count
//   cfg       sink  index, data: write to the peer limit (0) or peer_channel (1)
//
// The front parser takes one payload byte per cycle, and ready drops only
// when the four-entry queue is full. Each byte that causes results becomes
// one queue entry; the back end sends one result per cycle from its output
// register while result ready holds, and a last byte that also gives a header
// or name-byte result yields that result and then done. Reset is asynchronous
// and active low; it rearms the parser for a count byte, empties the queue
// and restores the peer limit to 16 and peer_channel to 1. A stalled
// result side fills the queue and holds off payload; no transaction is lost.
module peer_list_record_parser (
	input  logic           clk,
	input  logic           arst_n,
	plrp_byte_if.sink      payload,
	plrp_result_if.source  result,
	plrp_cfg_if.sink       cfg
);

	plrp_pkg::queue_status_t q_status;
	plrp_pkg::entry_t        push_entry;
	plrp_pkg::entry_t        head;
	logic                    push;
	logic                    pop;

	// The front classifies bytes and keeps all record state.
	plrp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.payload    (payload),
		.cfg        (cfg),
		.q_status   (q_status),
		.push       (push),
		.push_entry (push_entry)
	);

	// The queue lets the two sides stall independently.
	plrp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.status     (q_status)
	);

	// The back end turns each entry into its result transactions.
	plrp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_status (q_status),
		.pop      (pop),
		.result   (result)
	);

endmodule

/* design/plrp_front.sv */
// ----------------------------------------------------------------------------
// Parser front
// Accepts payload bytes, tracks record state and classifies each byte into
// a queue entry holding the results it causes.
// ----------------------------------------------------------------------------
module plrp_front (
	input  logic                    clk,
	input  logic                    arst_n,
	plrp_byte_if.sink               payload,
	plrp_cfg_if.sink                cfg,
	input  plrp_pkg::queue_status_t q_status,
	output logic                    push,
	output plrp_pkg::entry_t        push_entry
);

	localparam logic [1:0] PH_COUNT  = 2'd0;
	localparam logic [1:0] PH_HEADER = 2'd1;
	localparam logic [1:0] PH_NAME   = 2'd2;
	localparam logic [1:0] PH_SKIP   = 2'd3;

	logic [1:0]  phase_q, phase_d;
	logic [7:0]  records_left_q, records_left_d;
	logic [2:0]  hdr_idx_q, hdr_idx_d;
	logic [47:0] mac_q, mac_d;
	logic [7:0]  rssi_q, rssi_d;
	logic [5:0]  name_left_q, name_left_d;
	logic [4:0]  name_index_q, name_index_d;
	logic [7:0]  peers_q, peers_d;
	logic [7:0]  peer_limit_q;
	logic [3:0]  channel_q;

	logic        accept;
	logic [7:0]  cnt;
	logic [7:0]  nl;
	logic [7:0]  rec_dec;
	logic [5:0]  name_dec;
	plrp_pkg::entry_t ent;

	assign payload.ready = !q_status.full;
	assign accept        = payload.valid && payload.ready;
	assign cfg.ready     = 1'b1;

	assign rec_dec  = records_left_q - 8'd1;
	assign name_dec = name_left_q - 6'd1;
	assign cnt      = (payload.data_byte > peer_limit_q) ? peer_limit_q : payload.data_byte;
	assign nl       = (payload.data_byte > plrp_pkg::NAME_MAX) ? plrp_pkg::NAME_MAX
	                                                           : payload.data_byte;

	always_comb begin
		phase_d        = phase_q;
		records_left_d = records_left_q;
		hdr_idx_d      = hdr_idx_q;
		mac_d          = mac_q;
		rssi_d         = rssi_q;
		name_left_d    = name_left_q;
		name_index_d   = name_index_q;
		peers_d        = peers_q;
		ent            = '0;

		unique case (phase_q)
			PH_COUNT: begin
				records_left_d = cnt;
				hdr_idx_d      = 3'd0;
				mac_d          = '0;
				peers_d        = 8'd0;
				phase_d        = (cnt == 8'd0) ? PH_SKIP : PH_HEADER;
			end
			PH_HEADER: begin
				if (hdr_idx_q < plrp_pkg::HDR_MAC_BYTES) begin
					mac_d     = {mac_q[39:0], payload.data_byte};
					hdr_idx_d = hdr_idx_q + 3'd1;
				end else if (hdr_idx_q == plrp_pkg::HDR_RSSI_IDX) begin
					rssi_d    = payload.data_byte;
					hdr_idx_d = hdr_idx_q + 3'd1;
				end else begin
					ent.has_main         = 1'b1;
					ent.main.kind        = plrp_pkg::KIND_HEADER;
					ent.main.peer_index  = peers_q;
					ent.main.mac_address = mac_q;
					ent.main.rssi        = signed'(rssi_q);
					ent.main.channel_out = channel_q;
					ent.main.name_length = nl[5:0];
					peers_d              = peers_q + 8'd1;
					name_left_d          = nl[5:0];
					name_index_d         = 5'd0;
					mac_d                = '0;
					if (nl == 8'd0) begin
						records_left_d = rec_dec;
						hdr_idx_d      = 3'd0;
						phase_d        = (rec_dec == 8'd0) ? PH_SKIP : PH_HEADER;
					end else begin
						phase_d = PH_NAME;
					end
				end
			end
			PH_NAME: begin
				ent.has_main           = 1'b1;
				ent.main.kind          = plrp_pkg::KIND_NAME;
				ent.main.peer_index    = peers_q - 8'd1;
				ent.main.name_byte     = payload.data_byte;
				ent.main.name_position = name_index_q;
				ent.main.name_end      = (name_dec == 6'd0) || payload.last_byte;
				name_left_d            = name_dec;
				name_index_d           = name_index_q + 5'd1;
				if (name_dec == 6'd0) begin
					records_left_d = rec_dec;
					hdr_idx_d      = 3'd0;
					phase_d        = (rec_dec == 8'd0) ? PH_SKIP : PH_HEADER;
				end
			end
			PH_SKIP: begin
			end
		endcase

		if (payload.last_byte) begin
			ent.has_done   = 1'b1;
			ent.done_count = peers_d;
			phase_d        = PH_COUNT;
			records_left_d = '0;
			hdr_idx_d      = '0;
			mac_d          = '0;
			rssi_d         = '0;
			name_left_d    = '0;
			name_index_d   = '0;
			peers_d        = '0;
		end
	end

	assign push       = accept && (ent.has_main || ent.has_done);
	assign push_entry = ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_COUNT;
			records_left_q <= '0;
			hdr_idx_q      <= '0;
			mac_q          <= '0;
			rssi_q         <= '0;
			name_left_q    <= '0;
			name_index_q   <= '0;
			peers_q        <= '0;
		end else if (accept) begin
			phase_q        <= phase_d;
			records_left_q <= records_left_d;
			hdr_idx_q      <= hdr_idx_d;
			mac_q          <= mac_d;
			rssi_q         <= rssi_d;
			name_left_q    <= name_left_d;
			name_index_q   <= name_index_d;
			peers_q        <= peers_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peer_limit_q <= 8'd16;
			channel_q    <= 4'd1;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				plrp_pkg::CFG_PEER_LIMIT:   peer_limit_q <= cfg.data;
				plrp_pkg::CFG_PEER_CHANNEL: channel_q    <= cfg.data[3:0];
			endcase
		end
	end

endmodule

/* design/plrp_queue.sv */
// ----------------------------------------------------------------------------
// Entry queue
// Small first-in first-out store between the parser front and back end.
// ----------------------------------------------------------------------------
module plrp_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  plrp_pkg::entry_t        push_entry,
	input  logic                    pop,
	output plrp_pkg::entry_t        head,
	output plrp_pkg::queue_status_t status
);

	plrp_pkg::entry_t              mem_q [plrp_pkg::QUEUE_DEPTH];
	logic [plrp_pkg::QUEUE_AW-1:0] wr_ptr_q;
	logic [plrp_pkg::QUEUE_AW-1:0] rd_ptr_q;
	logic [plrp_pkg::QUEUE_AW:0]   count_q;

	assign status.full  = (count_q == (plrp_pkg::QUEUE_AW + 1)'(plrp_pkg::QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign head         = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + (plrp_pkg::QUEUE_AW)'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + (plrp_pkg::QUEUE_AW)'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (plrp_pkg::QUEUE_AW + 1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (plrp_pkg::QUEUE_AW + 1)'(1);
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (plrp_pkg::QUEUE_AW + 1)'(plrp_pkg::QUEUE_DEPTH))
		else $error("queue count beyond depth");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> !status.empty)
		else $error("queue popped while empty");
	assert property (@(posedge clk) disable iff (!arst_n) push |-> !status.full)
		else $error("queue pushed while full");

endmodule

/* design/plrp_back.sv */
// ----------------------------------------------------------------------------
// Result back end
// Expands queue entries into one or two result transactions through an
// output register.
// ----------------------------------------------------------------------------
module plrp_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  plrp_pkg::entry_t        head,
	input  plrp_pkg::queue_status_t q_status,
	output logic                    pop,
	plrp_result_if.source           result
);

	logic              out_valid_q;
	plrp_pkg::result_t out_q;
	logic              done_pending_q;
	logic [7:0]        done_count_q;

	logic              can_load;
	plrp_pkg::result_t done_res;

	assign can_load = !out_valid_q || result.ready;
	assign pop      = can_load && !done_pending_q && !q_status.empty;

	always_comb begin
		done_res            = '0;
		done_res.kind       = plrp_pkg::KIND_DONE;
		done_res.peer_count = done_pending_q ? done_count_q : head.done_count;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q    <= 1'b0;
			done_pending_q <= 1'b0;
		end else if (can_load) begin
			if (done_pending_q) begin
				out_valid_q    <= 1'b1;
				done_pending_q <= 1'b0;
			end else if (!q_status.empty) begin
				out_valid_q    <= 1'b1;
				done_pending_q <= head.has_main && head.has_done;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (can_load) begin
			if (done_pending_q) begin
				out_q <= done_res;
			end else if (!q_status.empty) begin
				out_q        <= head.has_main ? head.main : done_res;
				done_count_q <= head.done_count;
			end
		end
	end

	assign result.valid         = out_valid_q;
	assign result.kind          = out_q.kind;
	assign result.peer_index    = out_q.peer_index;
	assign result.mac_address   = out_q.mac_address;
	assign result.rssi          = out_q.rssi;
	assign result.channel_out   = out_q.channel_out;
	assign result.name_length   = out_q.name_length;
	assign result.name_byte     = out_q.name_byte;
	assign result.name_position = out_q.name_position;
	assign result.name_end      = out_q.name_end;
	assign result.peer_count    = out_q.peer_count;

endmodule
